FILE: rtl/keyed_location_set_store_top_defines.svh
// Assertion macros for the keyed location set store.
// Included by klss_datapath, which checks its own logic; needs no other file.
`ifndef KEYED_LOCATION_SET_STORE_TOP_DEFINES_SVH
`define KEYED_LOCATION_SET_STORE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KLSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("klss check failed");
`define KLSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("klss check failed");
`else
`define KLSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KLSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/klss_pkg.sv
// Shared types and constants of the keyed location set store.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package klss_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int MAX_LOCS_DEF  = 16;
    localparam int KEY_BITS_DEF  = 64;
    localparam int NODE_BITS_DEF = 64;
    localparam int MAX_RESULTS   = 16;
    localparam logic [31:0] EXPIRY_RESET = 32'd86400;

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_HAS    = 2'd2,
        FUNC_EXPIRE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DUP        = 3'd1,
        ST_ENTRY_FULL = 3'd2,
        ST_STORE_FULL = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [63:0] key;
        logic [63:0] node_id;
        logic [7:0]  addr_family;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
        logic        group_last;
        logic [4:0]  max_wanted;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [63:0] node_id_out;
        logic [7:0]  addr_family_out;
        logic [63:0] addr_hi_out;
        logic [63:0] addr_lo_out;
        logic [15:0] port_out;
        logic [4:0]  returned_count;
        logic [6:0]  entry_count;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_NEW,
        OP_DEDUP,
        OP_PUT_WR,
        OP_GET_RD,
        OP_OUT,
        OP_OUT_LOC,
        OP_EXP_RD,
        OP_EXP_NEXT,
        OP_EXP_SRC,
        OP_EXP_MOVE,
        OP_COPY,
        OP_EXP_DROP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
        logic    found;
        logic    use_glast;
        logic    append;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  scan_hit;
        logic  scan_miss;
        logic  store_full;
        logic  loc_full;
        logic  dup;
        logic  jdone;
        logic  get_zero;
        logic  get_last;
        logic  exp_done;
        logic  exp_old;
        logic  has_src;
        logic  out_busy;
    } dp_stat_t;

endpackage

FILE: rtl/klss_in_if.sv
// Request channel of the keyed location set store.
// Depends on klss_pkg for the request payload type.
`timescale 1ns / 1ps

interface klss_in_if;
    logic              valid;
    logic              ready;
    klss_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/klss_out_if.sv
// Result channel of the keyed location set store.
// Depends on klss_pkg for the result payload type.
`timescale 1ns / 1ps

interface klss_out_if;
    logic                valid;
    logic                ready;
    klss_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/keyed_location_set_store_top.sv
// Top level of the keyed location set store: joins controller and datapath.
// Depends on klss_pkg, klss_in_if, klss_out_if, klss_controller and klss_datapath.
//
//  Channel     Kind           Carries
//  item_ch     valid/ready    one request: put, get, has or expire
//  result_ch   valid/ready    one or more results per request
//  cfg_we      write strobe   expiry_seconds from cfg_wdata
//
// Requests are handled one at a time. The key search reads one entry per cycle;
// a put then scans the stored locations of its entry for a duplicate, and a get
// reads and returns its locations one by one. An expire walks the entries; a
// removed entry is replaced by the last entry, whose locations are copied into
// its slot. Memories need no clearing after reset; a stalled result channel
// holds the block in its current step.
`timescale 1ns / 1ps

module keyed_location_set_store_top #(
    parameter int CAPACITY  = klss_pkg::CAPACITY_DEF,
    parameter int MAX_LOCS  = klss_pkg::MAX_LOCS_DEF,
    parameter int KEY_BITS  = klss_pkg::KEY_BITS_DEF,
    parameter int NODE_BITS = klss_pkg::NODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    klss_in_if.sink     item_ch,
    klss_out_if.source  result_ch,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    klss_pkg::dp_cmd_t  cmd;
    klss_pkg::dp_stat_t stat;

    klss_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_ch.valid),
        .in_ready (item_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    klss_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_LOCS  (MAX_LOCS),
        .KEY_BITS  (KEY_BITS),
        .NODE_BITS (NODE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (item_ch.item),
        .out_item  (result_ch.item),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: rtl/klss_datapath.sv
// Datapath of the keyed location set store: entry and location memories,
// counters, compares and the result register. Depends on klss_pkg and the defines header.
`timescale 1ns / 1ps
`include "keyed_location_set_store_top_defines.svh"

module klss_datapath #(
    parameter int CAPACITY  = klss_pkg::CAPACITY_DEF,
    parameter int MAX_LOCS  = klss_pkg::MAX_LOCS_DEF,
    parameter int KEY_BITS  = klss_pkg::KEY_BITS_DEF,
    parameter int NODE_BITS = klss_pkg::NODE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  klss_pkg::in_item_t  in_item,
    output klss_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  klss_pkg::dp_cmd_t   cmd,
    output klss_pkg::dp_stat_t  stat
);

    localparam int EW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int LW    = (MAX_LOCS > 1) ? $clog2(MAX_LOCS) : 1;
    localparam int LCW   = $clog2(MAX_LOCS + 1);
    localparam int DEPTH = CAPACITY * MAX_LOCS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         stamp;
        logic [LCW-1:0]      cnt;
    } ent_word_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [7:0]           atype;
        logic [63:0]          hi;
        logic [63:0]          lo;
        logic [15:0]          port;
    } loc_word_t;

    ent_word_t ent_mem [CAPACITY];
    loc_word_t loc_mem [DEPTH];

    klss_pkg::func_t      func_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [NODE_BITS-1:0] node_reg;
    logic [7:0]           atype_reg;
    logic [63:0]          hi_reg;
    logic [63:0]          lo_reg;
    logic [15:0]          port_reg;
    logic                 glast_reg;
    logic [4:0]           want_reg;
    logic [31:0]          now_reg;
    logic [31:0]          expiry_reg;
    logic [CW-1:0]        total_reg;
    logic [CW-1:0]        scan_reg;
    logic                 pend_reg;
    logic [EW-1:0]        pidx_reg;
    logic [EW-1:0]        ent_reg;
    logic [EW-1:0]        src_reg;
    logic [LCW-1:0]       n_reg;
    logic [LCW-1:0]       j_reg;
    logic                 jpend_reg;
    logic [LW-1:0]        jw_reg;
    klss_pkg::out_item_t  out_reg;
    logic                 out_valid_reg;
    ent_word_t            ent_rd_reg;
    loc_word_t            loc_rd_reg;

    logic [CW-1:0]  total_m1;
    logic [EW-1:0]  ent_raddr;
    logic           ent_we;
    logic [EW-1:0]  ent_waddr;
    ent_word_t      ent_wdata;
    logic [LW-1:0]  jl;
    logic [EW-1:0]  loc_base;
    logic [AW-1:0]  loc_raddr;
    logic           loc_we;
    logic [AW-1:0]  loc_waddr;
    loc_word_t      loc_wdata;
    logic [6:0]     lim_a;
    logic [6:0]     get_cnt;
    logic [31:0]    age;
    logic           scan_hit;
    logic           out_load;
    logic           put_append;
    logic           op_new;

    always_comb
    begin
        out_load   = (cmd.op == klss_pkg::OP_OUT) || (cmd.op == klss_pkg::OP_OUT_LOC);
        put_append = (cmd.op == klss_pkg::OP_PUT_WR) && cmd.append;
        op_new     = cmd.op == klss_pkg::OP_NEW;
        total_m1 = total_reg - CW'(1);
        jl       = (j_reg < n_reg) ? j_reg[LW-1:0] : '0;
        loc_base = (cmd.op == klss_pkg::OP_COPY) ? src_reg : ent_reg;
        loc_raddr = AW'(loc_base) * AW'(MAX_LOCS) + AW'(jl);

        unique case (cmd.op)
            klss_pkg::OP_SCAN, klss_pkg::OP_EXP_RD: ent_raddr = scan_reg[EW-1:0];
            klss_pkg::OP_EXP_SRC:                   ent_raddr = total_m1[EW-1:0];
            default:                                ent_raddr = ent_reg;
        endcase

        ent_we    = (cmd.op == klss_pkg::OP_PUT_WR) || (cmd.op == klss_pkg::OP_EXP_MOVE);
        ent_waddr = (cmd.op == klss_pkg::OP_PUT_WR) ? ent_reg : scan_reg[EW-1:0];
        if (cmd.op == klss_pkg::OP_PUT_WR)
        begin
            ent_wdata.key   = key_reg;
            ent_wdata.stamp = now_reg;
            ent_wdata.cnt   = n_reg + LCW'(cmd.append);
        end
        else
        begin
            ent_wdata = ent_rd_reg;
        end

        if (cmd.op == klss_pkg::OP_PUT_WR)
        begin
            loc_we          = cmd.append;
            loc_waddr       = AW'(ent_reg) * AW'(MAX_LOCS) + AW'(n_reg[LW-1:0]);
            loc_wdata.node  = node_reg;
            loc_wdata.atype = atype_reg;
            loc_wdata.hi    = hi_reg;
            loc_wdata.lo    = lo_reg;
            loc_wdata.port  = port_reg;
        end
        else
        begin
            loc_we    = (cmd.op == klss_pkg::OP_COPY) && jpend_reg;
            loc_waddr = AW'(scan_reg[EW-1:0]) * AW'(MAX_LOCS) + AW'(jw_reg);
            loc_wdata = loc_rd_reg;
        end

        lim_a   = (7'(n_reg) < 7'(want_reg)) ? 7'(n_reg) : 7'(want_reg);
        get_cnt = (lim_a < 7'(klss_pkg::MAX_RESULTS)) ? lim_a : 7'(klss_pkg::MAX_RESULTS);
        age     = now_reg - ent_rd_reg.stamp;
        scan_hit = pend_reg && (ent_rd_reg.key == key_reg);

        stat.func       = func_reg;
        stat.scan_hit   = scan_hit;
        stat.scan_miss  = !pend_reg && (scan_reg >= total_reg);
        stat.store_full = total_reg >= CW'(CAPACITY);
        stat.loc_full   = n_reg >= LCW'(MAX_LOCS);
        stat.dup        = jpend_reg && (loc_rd_reg.node == node_reg);
        stat.jdone      = !jpend_reg && (j_reg >= n_reg);
        stat.get_zero   = get_cnt == 7'd0;
        stat.get_last   = (7'(j_reg) + 7'd1) == get_cnt;
        stat.exp_done   = scan_reg >= total_reg;
        stat.exp_old    = (now_reg > ent_rd_reg.stamp) && (age > expiry_reg);
        stat.has_src    = ({1'b0, scan_reg} + (CW + 1)'(1)) < {1'b0, total_reg};
        stat.out_busy   = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[ent_raddr];
        if (loc_we)
        begin
            loc_mem[loc_waddr] <= loc_wdata;
        end
        loc_rd_reg <= loc_mem[loc_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg    <= klss_pkg::EXPIRY_RESET;
            total_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            j_reg         <= '0;
            jpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expiry_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                klss_pkg::OP_LOAD:
                begin
                    scan_reg <= '0;
                    pend_reg <= 1'b0;
                end
                klss_pkg::OP_SCAN:
                begin
                    scan_reg  <= scan_reg + CW'(1);
                    pend_reg  <= scan_reg < total_reg;
                    j_reg     <= '0;
                    jpend_reg <= 1'b0;
                end
                klss_pkg::OP_NEW:
                begin
                    total_reg <= total_reg + CW'(1);
                    j_reg     <= '0;
                    jpend_reg <= 1'b0;
                end
                klss_pkg::OP_DEDUP, klss_pkg::OP_COPY:
                begin
                    j_reg     <= j_reg + LCW'(1);
                    jpend_reg <= j_reg < n_reg;
                end
                klss_pkg::OP_OUT_LOC:
                begin
                    j_reg <= j_reg + LCW'(1);
                end
                klss_pkg::OP_EXP_NEXT:
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
                klss_pkg::OP_EXP_DROP:
                begin
                    total_reg <= total_m1;
                end
                klss_pkg::OP_EXP_MOVE:
                begin
                    j_reg     <= '0;
                    jpend_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            klss_pkg::OP_LOAD:
            begin
                func_reg  <= in_item.func;
                key_reg   <= in_item.key[KEY_BITS-1:0];
                node_reg  <= in_item.node_id[NODE_BITS-1:0];
                atype_reg <= in_item.addr_family;
                hi_reg    <= in_item.addr_hi;
                lo_reg    <= in_item.addr_lo;
                port_reg  <= in_item.port;
                glast_reg <= in_item.group_last;
                want_reg  <= in_item.max_wanted;
                now_reg   <= in_item.now;
            end
            klss_pkg::OP_SCAN:
            begin
                pidx_reg <= scan_reg[EW-1:0];
                if (scan_hit)
                begin
                    ent_reg <= pidx_reg;
                    n_reg   <= ent_rd_reg.cnt;
                end
            end
            klss_pkg::OP_NEW:
            begin
                ent_reg <= total_reg[EW-1:0];
                n_reg   <= '0;
            end
            klss_pkg::OP_COPY:
            begin
                jw_reg <= jl;
            end
            klss_pkg::OP_EXP_MOVE:
            begin
                n_reg   <= ent_rd_reg.cnt;
                src_reg <= total_m1[EW-1:0];
            end
            klss_pkg::OP_OUT:
            begin
                out_reg.status          <= cmd.status;
                out_reg.found           <= cmd.found;
                out_reg.node_id_out     <= '0;
                out_reg.addr_family_out <= '0;
                out_reg.addr_hi_out     <= '0;
                out_reg.addr_lo_out     <= '0;
                out_reg.port_out        <= '0;
                out_reg.returned_count  <= '0;
                out_reg.entry_count     <= 7'(total_reg);
                out_reg.last            <= cmd.use_glast ? glast_reg : 1'b1;
            end
            klss_pkg::OP_OUT_LOC:
            begin
                out_reg.status          <= klss_pkg::ST_OK;
                out_reg.found           <= 1'b1;
                out_reg.node_id_out     <= 64'(loc_rd_reg.node);
                out_reg.addr_family_out <= loc_rd_reg.atype;
                out_reg.addr_hi_out     <= loc_rd_reg.hi;
                out_reg.addr_lo_out     <= loc_rd_reg.lo;
                out_reg.port_out        <= loc_rd_reg.port;
                out_reg.returned_count  <= get_cnt[4:0];
                out_reg.entry_count     <= 7'(total_reg);
                out_reg.last            <= stat.get_last;
            end
            default:
            begin
            end
        endcase
    end

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    `KLSS_ASSERT_IMP(a_total_bound, clk, rst_n, 1'b1, total_reg <= CW'(CAPACITY))
    `KLSS_ASSERT_IMP(a_out_free, clk, rst_n, out_load, !out_valid_reg)
    `KLSS_ASSERT_IMP(a_append_room, clk, rst_n, put_append, n_reg < LCW'(MAX_LOCS))
    `KLSS_ASSERT_NXT(a_new_grows, clk, rst_n, op_new, total_reg == $past(total_reg) + CW'(1))

endmodule

FILE: rtl/klss_controller.sv
// Controller of the keyed location set store: sequences lookup, put, get,
// has and expire through datapath commands. Depends on klss_pkg.
`timescale 1ns / 1ps

module klss_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  klss_pkg::dp_stat_t stat,
    output klss_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_NEW,
        S_HIT,
        S_DEDUP,
        S_PUT_WR,
        S_GET_RD,
        S_GET_OUT,
        S_OUT,
        S_EXP_RD,
        S_EXP_CHK,
        S_EXP_MV,
        S_COPY
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    klss_pkg::status_t st_reg;
    klss_pkg::status_t st_next;
    logic              found_reg;
    logic              found_next;
    logic              gsel_reg;
    logic              gsel_next;
    klss_pkg::dp_op_t  op;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        found_next = found_reg;
        gsel_next  = gsel_reg;
        op         = klss_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = klss_pkg::OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (stat.func == klss_pkg::FUNC_EXPIRE) ? S_EXP_RD : S_SCAN;
            end
            S_SCAN:
            begin
                op = klss_pkg::OP_SCAN;
                if (stat.scan_hit)
                begin
                    state_next = S_HIT;
                end
                else if (stat.scan_miss)
                begin
                    found_next = 1'b0;
                    if (stat.func == klss_pkg::FUNC_PUT)
                    begin
                        gsel_next = 1'b1;
                        if (stat.store_full)
                        begin
                            st_next    = klss_pkg::ST_STORE_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_NEW;
                        end
                    end
                    else
                    begin
                        gsel_next  = 1'b0;
                        st_next    = klss_pkg::ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                end
            end
            S_NEW:
            begin
                op         = klss_pkg::OP_NEW;
                state_next = S_HIT;
            end
            S_HIT:
            begin
                found_next = 1'b1;
                if (stat.func == klss_pkg::FUNC_PUT)
                begin
                    gsel_next = 1'b1;
                    if (stat.loc_full)
                    begin
                        st_next    = klss_pkg::ST_ENTRY_FULL;
                        state_next = S_PUT_WR;
                    end
                    else
                    begin
                        state_next = S_DEDUP;
                    end
                end
                else if ((stat.func == klss_pkg::FUNC_GET) && !stat.get_zero)
                begin
                    state_next = S_GET_RD;
                end
                else
                begin
                    st_next    = klss_pkg::ST_OK;
                    gsel_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_DEDUP:
            begin
                op = klss_pkg::OP_DEDUP;
                if (stat.dup)
                begin
                    st_next    = klss_pkg::ST_DUP;
                    state_next = S_PUT_WR;
                end
                else if (stat.jdone)
                begin
                    st_next    = klss_pkg::ST_OK;
                    state_next = S_PUT_WR;
                end
            end
            S_PUT_WR:
            begin
                op         = klss_pkg::OP_PUT_WR;
                state_next = S_OUT;
            end
            S_GET_RD:
            begin
                if (!stat.out_busy)
                begin
                    op         = klss_pkg::OP_GET_RD;
                    state_next = S_GET_OUT;
                end
            end
            S_GET_OUT:
            begin
                op         = klss_pkg::OP_OUT_LOC;
                state_next = stat.get_last ? S_IDLE : S_GET_RD;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    op         = klss_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            S_EXP_RD:
            begin
                if (stat.exp_done)
                begin
                    st_next    = klss_pkg::ST_OK;
                    found_next = 1'b0;
                    gsel_next  = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = klss_pkg::OP_EXP_RD;
                    state_next = S_EXP_CHK;
                end
            end
            S_EXP_CHK:
            begin
                if (!stat.exp_old)
                begin
                    op         = klss_pkg::OP_EXP_NEXT;
                    state_next = S_EXP_RD;
                end
                else if (stat.has_src)
                begin
                    op         = klss_pkg::OP_EXP_SRC;
                    state_next = S_EXP_MV;
                end
                else
                begin
                    op         = klss_pkg::OP_EXP_DROP;
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_MV:
            begin
                op         = klss_pkg::OP_EXP_MOVE;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                if (stat.jdone)
                begin
                    op         = klss_pkg::OP_EXP_DROP;
                    state_next = S_EXP_RD;
                end
                else
                begin
                    op = klss_pkg::OP_COPY;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= klss_pkg::ST_OK;
            found_reg <= 1'b0;
            gsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            found_reg <= found_next;
            gsel_reg  <= gsel_next;
        end
    end

    assign in_ready      = state_reg == S_IDLE;
    assign cmd.op        = op;
    assign cmd.status    = st_reg;
    assign cmd.found     = found_reg;
    assign cmd.use_glast = gsel_reg;
    assign cmd.append    = st_reg == klss_pkg::ST_OK;

endmodule
